@@ design/cascaded_interrupt_controller_macros.svh @@
// Assertion helpers shared by the controller RTL.
`ifndef CASCADED_INTERRUPT_CONTROLLER_MACROS_SVH
`define CASCADED_INTERRUPT_CONTROLLER_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define CIC_ASSERT_NOW(label, ant, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ant) |-> (cons)) \
        else $error("cic assertion failed");

// Next-cycle implication, disabled in reset.
`define CIC_ASSERT_NEXT(label, ant, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ant) |=> (cons)) \
        else $error("cic assertion failed");

`endif

@@ design/cic_pkg.sv @@
`default_nettype none

package cic_pkg;

    typedef enum logic [1:0] {
        CMD_WRITE  = 2'd0,
        CMD_READ   = 2'd1,
        CMD_SAMPLE = 2'd2,
        CMD_ACK    = 2'd3
    } t_cmd;

    typedef enum logic [3:0] {
        INIT_IDLE = 4'b0001,
        INIT_ICW2 = 4'b0010,
        INIT_ICW3 = 4'b0100,
        INIT_ICW4 = 4'b1000
    } t_init_state;

    localparam logic [7:0] ICW1_BIT     = 8'h10;
    localparam logic [7:0] OCW3_BIT     = 8'h08;
    localparam logic [7:0] OCW3_RR      = 8'h02;
    localparam logic [7:0] OCW3_RIS     = 8'h01;
    localparam logic [7:0] EOI_BIT      = 8'h20;
    localparam logic [7:0] OCW2_SL      = 8'h40;
    localparam logic [7:0] AUTO_EOI_BIT = 8'h02;

    localparam logic [3:0] MODE_IC4       = 4'h1;
    localparam logic [3:0] MODE_SNGL      = 4'h2;
    localparam logic [3:0] MODE_AEOI      = 4'h4;
    localparam logic [3:0] MODE_LTIM      = 4'h8;
    localparam logic [3:0] MODE_ICW1_MASK = MODE_IC4 | MODE_SNGL | MODE_LTIM;

    localparam logic [2:0] CASCADE_LINE = 3'd2;
    localparam logic [2:0] SPUR_LINE    = 3'd7;
    localparam logic [7:0] CASCADE_BIT  = 8'b0000_0100;

    typedef struct packed {
        logic [1:0]  cmd;
        logic        chip_sel;
        logic        port_sel;
        logic [7:0]  wdata;
        logic [15:0] irq_lines;
    } t_in_beat;

    typedef struct packed {
        logic [7:0] rdata;
        logic       intr;
        logic [7:0] vector;
        logic       vector_valid;
        logic       spurious;
    } t_out_beat;

    typedef struct packed {
        logic       fire;
        logic       wr;
        logic       sample;
        logic       ack;
        logic       port;
        logic [7:0] wdata;
        logic [7:0] lines;
        logic       casc_en;
        logic       casc_req;
    } t_chip_req;

    typedef struct packed {
        logic [7:0] rdata;
        logic [2:0] line;
        logic       empty;
        logic [4:0] vbase;
        logic       next_elig;
    } t_chip_rsp;

    // bits of lower number than the highest-priority in-service bit
    function automatic logic [7:0] f_below(input logic [7:0] isr);
        return (isr & (~isr + 8'd1)) - 8'd1;
    endfunction

    function automatic logic [2:0] f_lowest(input logic [7:0] v);
        logic [2:0] idx;
        idx = SPUR_LINE;
        for (int i = 7; i >= 0; i--) begin
            if (v[i]) begin
                idx = 3'(i);
            end
        end
        return idx;
    endfunction

endpackage

`default_nettype wire

@@ design/cic_chip.sv @@
`default_nettype none

`include "cascaded_interrupt_controller_macros.svh"

module cic_chip import cic_pkg::*; (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire t_chip_req i_req,
    output t_chip_rsp      o_rsp
);

    logic [7:0]  r_imr, n_imr;
    logic [7:0]  r_irr, n_irr;
    logic [7:0]  r_isr, n_isr;
    logic [4:0]  r_vbase, n_vbase;
    t_init_state r_init, n_init;
    logic [3:0]  r_mode, n_mode;
    logic [7:0]  r_casc, n_casc;
    logic [7:0]  r_prev, n_prev;
    logic        r_read_isr, n_read_isr;

    logic [7:0] w_elig;
    logic       w_empty;
    logic [2:0] w_line;
    logic [7:0] w_ack_bit;
    logic       w_do_ack;

    assign w_elig    = r_irr & ~r_imr & f_below(r_isr);
    assign w_empty   = (w_elig == 8'd0);
    assign w_line    = f_lowest(w_elig);
    assign w_ack_bit = 8'd1 << w_line;
    assign w_do_ack  = i_req.ack && !w_empty;

    always_comb begin
        n_imr      = r_imr;
        n_irr      = r_irr;
        n_isr      = r_isr;
        n_vbase    = r_vbase;
        n_init     = r_init;
        n_mode     = r_mode;
        n_casc     = r_casc;
        n_prev     = r_prev;
        n_read_isr = r_read_isr;

        if (i_req.wr) begin
            if (!i_req.port) begin
                if ((i_req.wdata & ICW1_BIT) != 8'd0) begin
                    n_init     = INIT_ICW2;
                    n_mode     = i_req.wdata[3:0] & MODE_ICW1_MASK;
                    n_imr      = 8'd0;
                    n_irr      = 8'd0;
                    n_isr      = 8'd0;
                    n_prev     = 8'hFF;
                    n_read_isr = 1'b0;
                end else if ((i_req.wdata & OCW3_BIT) != 8'd0) begin
                    if ((i_req.wdata & OCW3_RR) != 8'd0) begin
                        n_read_isr = (i_req.wdata & OCW3_RIS) != 8'd0;
                    end
                end else if ((i_req.wdata & EOI_BIT) != 8'd0) begin
                    if ((i_req.wdata & OCW2_SL) != 8'd0) begin
                        n_isr = r_isr & ~(8'd1 << i_req.wdata[2:0]);
                    end else begin
                        n_isr = r_isr & (r_isr - 8'd1);
                    end
                end
            end else begin
                case (r_init)
                    INIT_ICW2: begin
                        n_vbase = i_req.wdata[7:3];
                        if ((r_mode & MODE_SNGL) == 4'd0) begin
                            n_init = INIT_ICW3;
                        end else if ((r_mode & MODE_IC4) != 4'd0) begin
                            n_init = INIT_ICW4;
                        end else begin
                            n_init = INIT_IDLE;
                        end
                    end
                    INIT_ICW3: begin
                        n_casc = i_req.wdata;
                        n_init = ((r_mode & MODE_IC4) != 4'd0) ? INIT_ICW4 : INIT_IDLE;
                    end
                    INIT_ICW4: begin
                        if ((i_req.wdata & AUTO_EOI_BIT) != 8'd0) begin
                            n_mode = r_mode | MODE_AEOI;
                        end
                        n_init = INIT_IDLE;
                    end
                    default: begin
                        n_imr = i_req.wdata;
                    end
                endcase
            end
        end

        if (i_req.sample) begin
            if ((r_mode & MODE_LTIM) != 4'd0) begin
                n_irr = i_req.lines;
            end else begin
                n_irr = (r_irr | (i_req.lines & ~r_prev)) & i_req.lines;
            end
            n_prev = i_req.lines;
        end

        if (w_do_ack) begin
            if ((r_mode & MODE_AEOI) == 4'd0) begin
                n_isr = r_isr | w_ack_bit;
            end
            if ((r_mode & MODE_LTIM) == 4'd0) begin
                n_irr = r_irr & ~w_ack_bit;
            end
        end

        if (i_req.fire && i_req.casc_en) begin
            n_irr[CASCADE_LINE] = i_req.casc_req;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_imr      <= 8'hFF;
            r_irr      <= 8'd0;
            r_isr      <= 8'd0;
            r_vbase    <= 5'd0;
            r_init     <= INIT_IDLE;
            r_mode     <= 4'd0;
            r_casc     <= 8'd0;
            r_prev     <= 8'd0;
            r_read_isr <= 1'b0;
        end else begin
            r_imr      <= n_imr;
            r_irr      <= n_irr;
            r_isr      <= n_isr;
            r_vbase    <= n_vbase;
            r_init     <= n_init;
            r_mode     <= n_mode;
            r_casc     <= n_casc;
            r_prev     <= n_prev;
            r_read_isr <= n_read_isr;
        end
    end

    always_comb begin
        o_rsp.rdata     = i_req.port ? r_imr : (r_read_isr ? r_isr : r_irr);
        o_rsp.line      = w_line;
        o_rsp.empty     = w_empty;
        o_rsp.vbase     = r_vbase;
        o_rsp.next_elig = (n_irr & ~n_imr & f_below(n_isr)) != 8'd0;
    end

    `CIC_ASSERT_NEXT(a_ack_sets_isr,
        w_do_ack && ((r_mode & MODE_AEOI) == 4'd0),
        (r_isr & $past(w_ack_bit)) == $past(w_ack_bit))
    `CIC_ASSERT_NEXT(a_icw1_starts_init,
        i_req.wr && !i_req.port && ((i_req.wdata & ICW1_BIT) != 8'd0),
        r_init == INIT_ICW2 && r_isr == 8'd0 && r_imr == 8'd0)
    `CIC_ASSERT_NOW(a_init_onehot, 1'b1, $onehot(r_init))

endmodule

`default_nettype wire

@@ design/cascaded_interrupt_controller.sv @@
// Master/slave pair of fixed-priority interrupt controllers (slave on master
// line 2) driven by bus writes, bus reads, request line samples and acknowledges.
// Every beat gives exactly one result beat. Throughput is one beat per clock
// while the result side does not stall; a beat passes the input and the result
// register, with all decode, priority and state update done between them.
// Stall on the result side holds the result register and stalls the input side
// only once the input register is also occupied. NUM_CHIPS = 1 removes the slave.
`default_nettype none

`include "cascaded_interrupt_controller_macros.svh"

module cascaded_interrupt_controller import cic_pkg::*; #(
    parameter int NUM_CHIPS = 2
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    output logic           o_in_stall,
    input  wire t_in_beat  i_in_beat,
    output logic           o_out_valid,
    input  wire logic      i_out_stall,
    output t_out_beat      o_out_beat
);

    localparam bit TWO_CHIPS = (NUM_CHIPS >= 2);

    logic      r_in_valid;
    t_in_beat  r_in;
    logic      r_out_valid;
    t_out_beat r_out;
    t_out_beat n_out;

    logic      w_out_block;
    logic      w_fire;
    logic      w_accept;

    t_chip_req w_m_req, w_s_req;
    t_chip_rsp w_m_rsp, w_s_rsp;

    assign w_out_block = r_out_valid && i_out_stall;
    assign o_in_stall  = r_in_valid && w_out_block;
    assign w_fire      = r_in_valid && !w_out_block;
    assign w_accept    = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_in_valid <= 1'b1;
            end else if (w_fire) begin
                r_in_valid <= 1'b0;
            end
            if (w_fire) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_in <= i_in_beat;
        end
        if (w_fire) begin
            r_out <= n_out;
        end
    end

    always_comb begin
        w_m_req.fire     = w_fire;
        w_m_req.wr       = w_fire && (r_in.cmd == CMD_WRITE) && !r_in.chip_sel;
        w_m_req.sample   = w_fire && (r_in.cmd == CMD_SAMPLE);
        w_m_req.ack      = w_fire && (r_in.cmd == CMD_ACK);
        w_m_req.port     = r_in.port_sel;
        w_m_req.wdata    = r_in.wdata;
        w_m_req.lines    = r_in.irq_lines[7:0] & ~CASCADE_BIT;
        w_m_req.casc_en  = TWO_CHIPS;
        w_m_req.casc_req = w_s_rsp.next_elig;

        w_s_req.fire     = w_fire;
        w_s_req.wr       = w_fire && (r_in.cmd == CMD_WRITE) && r_in.chip_sel;
        w_s_req.sample   = w_fire && (r_in.cmd == CMD_SAMPLE);
        w_s_req.ack      = w_m_req.ack && !w_m_rsp.empty && (w_m_rsp.line == CASCADE_LINE);
        w_s_req.port     = r_in.port_sel;
        w_s_req.wdata    = r_in.wdata;
        w_s_req.lines    = r_in.irq_lines[15:8];
        w_s_req.casc_en  = 1'b0;
        w_s_req.casc_req = 1'b0;
    end

    cic_chip u_master (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_m_req),
        .o_rsp   (w_m_rsp)
    );

    generate
        if (TWO_CHIPS) begin : g_slave
            cic_chip u_slave (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_req   (w_s_req),
                .o_rsp   (w_s_rsp)
            );
        end else begin : g_no_slave
            assign w_s_rsp = '{rdata: 8'd0, line: SPUR_LINE, empty: 1'b1,
                               vbase: 5'd0, next_elig: 1'b0};
        end
    endgenerate

    always_comb begin
        n_out              = '0;
        n_out.intr         = w_m_rsp.next_elig;
        n_out.vector_valid = (r_in.cmd == CMD_ACK);
        case (r_in.cmd)
            CMD_READ: begin
                n_out.rdata = r_in.chip_sel ? w_s_rsp.rdata : w_m_rsp.rdata;
            end
            CMD_ACK: begin
                if (w_m_rsp.empty) begin
                    n_out.spurious = 1'b1;
                    n_out.vector   = {w_m_rsp.vbase, SPUR_LINE};
                end else if (w_s_req.ack && TWO_CHIPS) begin
                    n_out.spurious = w_s_rsp.empty;
                    n_out.vector   = {w_s_rsp.vbase, w_s_rsp.line};
                end else begin
                    n_out.vector   = {w_m_rsp.vbase, w_m_rsp.line};
                end
            end
            default: begin
                n_out.rdata = 8'd0;
            end
        endcase
    end

    assign o_out_valid = r_out_valid;
    assign o_out_beat  = r_out;

    `CIC_ASSERT_NEXT(a_fire_loads_result, w_fire,
        r_out_valid && (r_out.vector_valid == ($past(r_in.cmd) == CMD_ACK)))
    `CIC_ASSERT_NOW(a_spurious_is_ir7, r_out_valid && r_out.spurious,
        r_out.vector_valid && (r_out.vector[2:0] == SPUR_LINE))
    `CIC_ASSERT_NOW(a_no_vector_without_ack, r_out_valid && !r_out.vector_valid,
        (r_out.vector == 8'd0) && !r_out.spurious)

endmodule

`default_nettype wire
